[rtl/glot_pkg.sv]
// Package for the grid line obstacle trace block.
// Holds the shared constants, register indexes and the sequencer state type.
// Depends on nothing; used by rtl/grid_line_obstacle_trace_core.sv.
package glot_pkg;

  // Default number of cells along each side of the stored occupancy grid.
  localparam int GRID_DIM_DEF = 64;

  // Fixed field widths.
  localparam int COORD_W = 16;
  localparam int LIMIT_W = 7;
  localparam int CELL_W  = 6;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  // Reset values of the limit registers.
  localparam logic [LIMIT_W-1:0] GRID_WIDTH_RST  = 7'd64;
  localparam logic [LIMIT_W-1:0] GRID_HEIGHT_RST = 7'd64;

  // Request kinds on the input channel.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_TRACE = 1'b1;

  // Packed widths of the stream payloads.
  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 32;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STEP,
    ST_CHECK,
    ST_DONE
  } state_t;

endpackage

[rtl/grid_line_obstacle_trace_core.sv]
// Top level of the grid line obstacle trace block: occupancy memory, walk
// sequencer and output register in one module.
// Depends on rtl/glot_pkg.sv.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | s_tuser = kind, s_tdata = cell and trace
//  m_*      | out       | m_tvalid/m_tready  | m_tuser = reached_goal, m_tdata = reach
//  cfg_*    | in        | cfg_we (no wait)   | cfg_index, cfg_data = grid limit
//
// After reset the occupancy memory is cleared one cell per cycle; no request is
// taken then. A write request is done as it is taken, and the block stays
// ready. A trace request steps cell by cell, each cell passing through ST_STEP
// (address and limit check) and then ST_CHECK (registered memory read and
// decision). The single memory read port is read once per step. The finished
// result waits in an output register, so the next request is taken while it is
// held; a second trace that finishes before the first result is taken waits for it.
module grid_line_obstacle_trace_core #(
  parameter int GRID_DIM = glot_pkg::GRID_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input request stream.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // Fields from bit 0 up: cell_x[5:0], cell_y[11:6], cell_blocked[12],
  // origin_x[28:13], origin_y[44:29], target_x[60:45], target_y[76:61],
  // zero fill[79:77].
  input  logic [glot_pkg::S_TDATA_W-1:0]      s_tdata,
  // Fields from bit 0 up: kind[0].
  input  logic                                s_tuser,
  // Result stream.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // Fields from bit 0 up: reach_x[15:0], reach_y[31:16].
  output logic [glot_pkg::M_TDATA_W-1:0]      m_tdata,
  // Fields from bit 0 up: reached_goal[0].
  output logic                                m_tuser,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [glot_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [glot_pkg::LIMIT_W-1:0]        cfg_data
);

  localparam int DEPTH  = GRID_DIM * GRID_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CW     = glot_pkg::COORD_W;

  // Request fields.
  logic                           kind;
  logic [glot_pkg::CELL_W-1:0]    cell_x;
  logic [glot_pkg::CELL_W-1:0]    cell_y;
  logic                           cell_blocked;
  logic signed [CW-1:0]           origin_x;
  logic signed [CW-1:0]           origin_y;
  logic signed [CW-1:0]           target_x;
  logic signed [CW-1:0]           target_y;

  assign kind         = s_tuser;
  assign cell_x       = s_tdata[5:0];
  assign cell_y       = s_tdata[11:6];
  assign cell_blocked = s_tdata[12];
  assign origin_x     = s_tdata[28:13];
  assign origin_y     = s_tdata[44:29];
  assign target_x     = s_tdata[60:45];
  assign target_y     = s_tdata[76:61];

  // Configuration registers.
  logic [glot_pkg::LIMIT_W-1:0] grid_width;
  logic [glot_pkg::LIMIT_W-1:0] grid_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= glot_pkg::GRID_WIDTH_RST;
      grid_height <= glot_pkg::GRID_HEIGHT_RST;
    end else if (cfg_we) begin
      if (cfg_index == glot_pkg::REG_GRID_WIDTH) begin
        grid_width <= cfg_data;
      end
      if (cfg_index == glot_pkg::REG_GRID_HEIGHT) begin
        grid_height <= cfg_data;
      end
    end
  end

  // Limits above the stored grid size act as the stored size.
  logic [CW-1:0] width_eff;
  logic [CW-1:0] height_eff;

  assign width_eff  = (CW'(grid_width) > CW'(GRID_DIM)) ? CW'(GRID_DIM) : CW'(grid_width);
  assign height_eff = (CW'(grid_height) > CW'(GRID_DIM)) ? CW'(GRID_DIM) : CW'(grid_height);

  // Sequencer and walk registers.
  glot_pkg::state_t     state;
  glot_pkg::state_t     state_next;
  logic [ADDR_W-1:0]    clr_cnt;
  logic signed [CW-1:0] px;
  logic signed [CW-1:0] py;
  logic signed [CW-1:0] gx;
  logic signed [CW-1:0] gy;
  logic signed [CW-1:0] nx;
  logic signed [CW-1:0] ny;
  logic                 in_range_q;
  logic                 reached;
  logic                 rd_q;

  logic                 s_fire;
  logic                 out_load;

  assign s_fire = s_tvalid && s_tready;

  // Shared step unit: remaining distances, axis choice, candidate cell and
  // its limit check.
  logic signed [CW:0]   dx;
  logic signed [CW:0]   dy;
  logic [CW:0]          adx;
  logic [CW:0]          ady;
  logic                 move_x;
  logic                 at_goal;
  logic signed [CW-1:0] cand_x;
  logic signed [CW-1:0] cand_y;
  logic                 cand_in;
  logic [ADDR_W-1:0]    cand_addr;

  always_comb begin
    dx      = {gx[CW-1], gx} - {px[CW-1], px};
    dy      = {gy[CW-1], gy} - {py[CW-1], py};
    adx     = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
    ady     = dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);
    move_x  = adx > ady;
    at_goal = (px == gx) && (py == gy);
    cand_x  = px;
    cand_y  = py;
    if (move_x) begin
      cand_x = dx[CW] ? px - CW'(1) : px + CW'(1);
    end else begin
      cand_y = dy[CW] ? py - CW'(1) : py + CW'(1);
    end
    cand_in = !cand_x[CW-1] && !cand_y[CW-1] &&
              ($unsigned(cand_x) < width_eff) && ($unsigned(cand_y) < height_eff);
    cand_addr = ADDR_W'(ADDR_W'(cand_y) * ADDR_W'(GRID_DIM)) + ADDR_W'(cand_x);
  end

  // Occupancy memory: one bit per cell, cell (x,y) at y*GRID_DIM+x.
  logic              mem [DEPTH];
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_data;
  logic              cell_in_store;

  assign cell_in_store = (CW'(cell_x) < CW'(GRID_DIM)) && (CW'(cell_y) < CW'(GRID_DIM));

  always_comb begin
    if (state == glot_pkg::ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = 1'b0;
    end else begin
      wr_en   = s_fire && (kind == glot_pkg::KIND_WRITE) && cell_in_store;
      wr_addr = ADDR_W'(ADDR_W'(cell_y) * ADDR_W'(GRID_DIM)) + ADDR_W'(cell_x);
      wr_data = cell_blocked;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[cand_addr];
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= glot_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      glot_pkg::ST_CLEAR: begin
        if (clr_cnt == ADDR_W'(DEPTH - 1)) begin
          state_next = glot_pkg::ST_IDLE;
        end
      end
      glot_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && kind == glot_pkg::KIND_TRACE) begin
          state_next = glot_pkg::ST_STEP;
        end
      end
      glot_pkg::ST_STEP: begin
        state_next = at_goal ? glot_pkg::ST_DONE : glot_pkg::ST_CHECK;
      end
      glot_pkg::ST_CHECK: begin
        if (in_range_q && !rd_q) begin
          state_next = glot_pkg::ST_STEP;
        end else begin
          state_next = glot_pkg::ST_DONE;
        end
      end
      glot_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = glot_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = glot_pkg::ST_IDLE;
      end
    endcase
  end

  // Clear counter for the pass after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == glot_pkg::ST_CLEAR) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  // Walk datapath. The origin is taken as the first position unchecked; each
  // candidate is held for the cycle in which its memory bit comes back.
  always_ff @(posedge clk) begin
    if (s_fire && kind == glot_pkg::KIND_TRACE) begin
      px <= origin_x;
      py <= origin_y;
      gx <= target_x;
      gy <= target_y;
    end else if (state == glot_pkg::ST_CHECK && in_range_q && !rd_q) begin
      px <= nx;
      py <= ny;
    end
    if (state == glot_pkg::ST_STEP) begin
      nx         <= cand_x;
      ny         <= cand_y;
      in_range_q <= cand_in;
      reached    <= at_goal;
    end
  end

  // Output register.
  logic                 out_valid;
  logic signed [CW-1:0] reach_x;
  logic signed [CW-1:0] reach_y;
  logic                 reached_goal;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      reach_x      <= px;
      reach_y      <= py;
      reached_goal <= reached;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {reach_y, reach_x};
  assign m_tuser  = reached_goal;

`ifndef SYNTH
  // A walk that stepped to a cell outside the limits ends at once.
  a_stop_outside: assert property (@(posedge clk) disable iff (rst)
    (state == glot_pkg::ST_CHECK && !in_range_q) |=> state == glot_pkg::ST_DONE)
    else $error("walk continued past a cell outside the grid limits");

  // A walk marked as reaching the goal stands on the goal.
  a_goal_pos: assert property (@(posedge clk) disable iff (rst)
    (state == glot_pkg::ST_DONE && reached) |-> (px == gx && py == gy))
    else $error("goal flag set away from the goal");

  // A new result appears only from the finishing state.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == glot_pkg::ST_DONE)
    else $error("result raised outside the finishing state");
`endif

endmodule
